// File: sv/binary_to_decimal_ascii_defines.svh
// Assertion macros shared by the binary to decimal ASCII converter modules.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define B2DA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/b2da_pkg.sv
// Types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

    localparam int VALUE_W    = 64;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CHAR_W     = 6;
    localparam int SHIFT_CNT_W = $clog2(VALUE_W);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0]  ASCII_NINE = 6'd57;
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } dab_status_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SKIP,
        EM_EMIT
    } emit_state_t;

endpackage

// File: sv/b2da_dabble.sv
// Bit-serial double dabble: shifts the binary value into a 20-digit BCD register.
`include "binary_to_decimal_ascii_defines.svh"

module b2da_dabble
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [b2da_pkg::VALUE_W-1:0]    value,
    output b2da_pkg::dab_status_t           status,
    output logic [b2da_pkg::BCD_W-1:0]      bcd
);

    logic [b2da_pkg::VALUE_W-1:0]     bin_reg;
    logic [b2da_pkg::BCD_W-1:0]       bcd_reg;
    logic [b2da_pkg::BCD_W-1:0]       bcd_adj;
    logic [b2da_pkg::SHIFT_CNT_W-1:0] cnt_reg;
    logic [b2da_pkg::SHIFT_CNT_W-1:0] cnt_next;
    logic                             busy_reg;
    logic                             busy_next;
    logic                             done_reg;
    logic                             done_next;
    logic                             last_shift;

    // add-3 on every digit of 5 or more before the shift
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= b2da_pkg::DABBLE_LIMIT)
            begin
                bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                    bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + b2da_pkg::DABBLE_ADD;
            end
        end
    end

    assign last_shift = (cnt_reg == b2da_pkg::SHIFT_CNT_W'(b2da_pkg::VALUE_W - 1));

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (load)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last_shift)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= {bin_reg[b2da_pkg::VALUE_W-2:0], 1'b0};
            bcd_reg <= {bcd_adj[b2da_pkg::BCD_W-2:0], bin_reg[b2da_pkg::VALUE_W-1]};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

    `B2DA_ASSERT_NEXT(a_load_starts, load, busy_reg && cnt_reg == '0, "dabble did not start on load")
    `B2DA_ASSERT_NEXT(a_done_after_last, busy_reg && last_shift && !load, done_reg && !busy_reg,
        "dabble did not finish after the last shift")
    `B2DA_ASSERT_NOW(a_done_not_busy, done_reg, !busy_reg, "dabble done while still shifting")

endmodule

// File: sv/b2da_emit.sv
// Digit emitter: drops leading zeros and sends one ASCII digit per cycle.
`include "binary_to_decimal_ascii_defines.svh"

module b2da_emit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [b2da_pkg::BCD_W-1:0]   bcd,
    output logic [b2da_pkg::CHAR_W-1:0]  digit_char,
    output logic                         last,
    output logic                         strobe,
    output logic                         busy
);

    b2da_pkg::emit_state_t            state_reg;
    b2da_pkg::emit_state_t            state_next;
    logic [b2da_pkg::BCD_W-1:0]       dig_reg;
    logic [b2da_pkg::BCD_W-1:0]       dig_next;
    logic [b2da_pkg::REM_W-1:0]       rem_reg;
    logic [b2da_pkg::REM_W-1:0]       rem_next;
    logic [b2da_pkg::DIGIT_W-1:0]     top_digit;
    logic                             one_left;

    assign top_digit = dig_reg[b2da_pkg::BCD_W-1 -: b2da_pkg::DIGIT_W];
    assign one_left  = (rem_reg == b2da_pkg::REM_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b2da_pkg::EM_IDLE;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
    end

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        rem_next   = rem_reg;
        strobe     = 1'b0;
        last       = 1'b0;
        digit_char = b2da_pkg::ASCII_ZERO
                   + {{(b2da_pkg::CHAR_W - b2da_pkg::DIGIT_W){1'b0}}, top_digit};
        case (state_reg)
            b2da_pkg::EM_IDLE:
            begin
                if (load)
                begin
                    dig_next   = bcd;
                    rem_next   = b2da_pkg::REM_W'(b2da_pkg::NUM_DIGITS);
                    state_next = b2da_pkg::EM_SKIP;
                end
            end
            b2da_pkg::EM_SKIP:
            begin
                // strip leading zeros, keep at least one digit
                if (top_digit == '0 && !one_left)
                begin
                    dig_next = {dig_reg[b2da_pkg::BCD_W-b2da_pkg::DIGIT_W-1:0],
                                {b2da_pkg::DIGIT_W{1'b0}}};
                    rem_next = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = b2da_pkg::EM_EMIT;
                end
            end
            b2da_pkg::EM_EMIT:
            begin
                strobe   = 1'b1;
                last     = one_left;
                dig_next = {dig_reg[b2da_pkg::BCD_W-b2da_pkg::DIGIT_W-1:0],
                            {b2da_pkg::DIGIT_W{1'b0}}};
                rem_next = rem_reg - 1'b1;
                if (one_left)
                begin
                    state_next = b2da_pkg::EM_IDLE;
                end
            end
            default:
            begin
                state_next = b2da_pkg::EM_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != b2da_pkg::EM_IDLE);

    `B2DA_ASSERT_NOW(a_char_range, strobe,
        digit_char >= b2da_pkg::ASCII_ZERO && digit_char <= b2da_pkg::ASCII_NINE,
        "emitted character is not a decimal digit")
    `B2DA_ASSERT_NEXT(a_run_continues, strobe && !last, strobe, "digit run broken before last")
    `B2DA_ASSERT_NEXT(a_run_ends, strobe && last, !strobe && !busy, "emitter active after last digit")

endmodule

// File: sv/binary_to_decimal_ascii.sv
// Digits of a value leave most significant first, one digit per cycle from the first
// digit to the last. A new value is taken only when the previous one is through: each
// value passes the 64 bit-serial double dabble shifts, then a 20-digit zero-strip/emit
// scan. Digits cannot be stalled by the receiver.
// Reset: asynchronous, active low; returns both units to idle, nothing else is kept.
module binary_to_decimal_ascii
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [b2da_pkg::VALUE_W-1:0]    value,
    output logic                            busy,
    output logic                            strobe,
    output logic [b2da_pkg::CHAR_W-1:0]     digit_char,
    output logic                            last
);

    b2da_pkg::dab_status_t          dab_status;
    logic [b2da_pkg::BCD_W-1:0]     bcd;
    logic                           emit_busy;
    logic                           accept;

    // transaction accepted on start while idle
    assign accept = start && !busy;
    assign busy   = dab_status.busy || dab_status.done || emit_busy;

    b2da_dabble u_dabble
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .value  (value),
        .status (dab_status),
        .bcd    (bcd)
    );

    b2da_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (dab_status.done),
        .bcd        (bcd),
        .digit_char (digit_char),
        .last       (last),
        .strobe     (strobe),
        .busy       (emit_busy)
    );

endmodule

// File: tb/tb_binary_to_decimal_ascii.sv
// Self-checking testbench for the binary to decimal ASCII converter.
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii;

    localparam int N_DIRECTED  = 20;
    localparam int N_RANDOM    = 320;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 100;

    typedef struct {
        logic [b2da_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } digit_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic [b2da_pkg::VALUE_W-1:0] value;
    logic                         busy;
    logic                         strobe;
    logic [b2da_pkg::CHAR_W-1:0]  digit_char;
    logic                         last;

    digit_t pending_digits[$];
    string  known_text;
    bit     gaps_on;
    bit     failed;
    int     quiet_cycles;

    logic [b2da_pkg::VALUE_W-1:0] directed_values [N_DIRECTED] = '{
        64'd0,
        64'd1,
        64'd9,
        64'd10,
        64'd99,
        64'd100,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'd9999999999999999999,
        64'd10000000000000000000,
        64'h8000_0000_0000_0000,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'h0000_0000_FFFF_FFFF,
        64'h0000_0001_0000_0000,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'd12345678901234567890,
        64'd1000000000,
        64'd18446744073709551614,
        64'd1844674407370955161,
        64'd7
    };

    // empty text: expectation comes from the digit predictor
    string directed_texts [N_DIRECTED] = '{
        "0", "", "", "", "", "",
        "18446744073709551615",
        "",
        "10000000000000000000",
        "", "", "", "", "", "", "", "", "", "", ""
    };

    binary_to_decimal_ascii DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .busy       (busy),
        .strobe     (strobe),
        .digit_char (digit_char),
        .last       (last)
    );

    always #4 clk = ~clk;

    function automatic void predict_decimal_digits(input logic [b2da_pkg::VALUE_W-1:0] v);
        logic [b2da_pkg::VALUE_W-1:0] rem;
        logic [3:0]                   lsd_first [b2da_pkg::NUM_DIGITS];
        int                           n;
        digit_t                       d;
        rem = v;
        n = 0;
        if (rem == '0)
        begin
            lsd_first[0] = 4'd0;
            n = 1;
        end
        while (rem != '0)
        begin
            lsd_first[n] = 4'(rem % 64'd10);
            rem = rem / 64'd10;
            n++;
        end
        for (int k = 0; k < n; k++)
        begin
            d.ch   = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(lsd_first[n-1-k]);
            d.last = (k == n - 1);
            pending_digits.push_back(d);
        end
    endfunction

    function automatic void push_known_text(input string s);
        byte    b;
        digit_t d;
        for (int i = 0; i < s.len(); i++)
        begin
            b      = s[i];
            d.ch   = b[b2da_pkg::CHAR_W-1:0];
            d.last = (i == s.len() - 1);
            pending_digits.push_back(d);
        end
    endfunction

    // digit check, expectation capture and watchdog
    always @(posedge clk)
    begin
        digit_t exp_d;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (pending_digits.size() == 0)
                begin
                    $display("%0t: unexpected digit: char %0d last %0b",
                             $time, digit_char, last);
                    failed = 1'b1;
                end
                else
                begin
                    exp_d = pending_digits.pop_front();
                    if (digit_char !== exp_d.ch || last !== exp_d.last)
                    begin
                        $display("%0t: mismatch: expected char %0d last %0b, got char %0d last %0b",
                                 $time, exp_d.ch, exp_d.last, digit_char, last);
                        failed = 1'b1;
                    end
                end
            end
            if (start && !busy)
            begin
                if (known_text.len() != 0)
                    push_known_text(known_text);
                else
                    predict_decimal_digits(value);
            end
        end
        if ((rst_n && start && !busy) || (rst_n && strobe))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_value(input logic [b2da_pkg::VALUE_W-1:0] v, input string text);
        bit taken;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            if (gaps_on && $urandom_range(99) < 13)
                start <= 1'b0;
            else
            begin
                start      <= 1'b1;
                value      <= v;
                known_text = text;
            end
            @(posedge clk);
            taken = start && !busy;
        end
    endtask

    function automatic logic [b2da_pkg::VALUE_W-1:0] random_value();
        logic [b2da_pkg::VALUE_W-1:0] v;
        logic [b2da_pkg::VALUE_W-1:0] p;
        int                           mode;
        int                           w;
        mode = $urandom_range(9);
        v = {$urandom, $urandom};
        if (mode <= 4)
        begin
            w = $urandom_range(1, b2da_pkg::VALUE_W);
            v = v >> (b2da_pkg::VALUE_W - w);
        end
        else if (mode <= 6)
            v = v;
        else if (mode <= 8)
        begin
            // around a power of ten, where the digit count changes
            p = 64'd1;
            repeat ($urandom_range(0, 19)) p = p * 64'd10;
            v = p + b2da_pkg::VALUE_W'($urandom_range(0, 2)) - 64'd1;
        end
        else
            v = b2da_pkg::VALUE_W'($urandom_range(0, 1000));
        return v;
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        value        = '0;
        known_text   = "";
        gaps_on      = 1'b1;
        failed       = 1'b0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_value(directed_values[i], directed_texts[i]);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            gaps_on = !(i >= 100 && i < 180);
            if (i == 200)
            begin
                @(negedge clk);
                start <= 1'b0;
                while (pending_digits.size() != 0)
                    @(negedge clk);
            end
            send_value(random_value(), "");
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (!failed && pending_digits.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
